// ----- src/gpio_serial_rtc_port_macros.svh -----
// Assertion macros shared by the gpio_serial_rtc_port RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef GPIO_SERIAL_RTC_PORT_MACROS_SVH
`define GPIO_SERIAL_RTC_PORT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define GSRP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define GSRP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/gsrp_pkg.sv -----
// Package for the GPIO serial RTC port: beat types, register codes,
// RTC command constants and the command bit-reverse helper. No dependencies.
package gsrp_pkg;

    // Access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Register indexes (anything else is pin data)
    localparam logic [1:0] REG_DIR    = 2'd1;
    localparam logic [1:0] REG_RD_EN  = 2'd2;

    // Pin bit positions
    localparam int PIN_CLK = 0;
    localparam int PIN_SIO = 1;
    localparam int PIN_SEL = 2;

    // Command decode
    localparam logic [7:0] CMD_HI_MASK  = 8'hF0;
    localparam logic [7:0] CMD_NO_REV   = 8'h60;
    localparam logic [3:0] CMD_BITS     = 4'd8;
    localparam logic [2:0] CMD_STATUS   = 3'd1;
    localparam logic [2:0] CMD_DATETIME = 3'd2;
    localparam logic [2:0] CMD_TIME     = 3'd3;

    // Fixed responses
    localparam logic [47:0] RSP_STATUS   = 48'h0000_0000_0040;
    localparam logic [47:0] RSP_DATETIME = 48'h5113_0306_0825;
    localparam logic [47:0] RSP_TIME     = 48'h0000_0051_1303;

    // Stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;

    typedef struct packed {
        logic       opcode;
        logic [1:0] reg_index;
        logic [3:0] write_data;
    } t_item;

    typedef struct packed {
        logic       valid;
        logic [3:0] read_data;
    } t_result;

    function automatic logic [7:0] reverse8(input logic [7:0] x);
        logic [7:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r[i] = x[7 - i];
        end
        return r;
    endfunction

endpackage

// ----- src/gsrp_in_stage.sv -----
// Input register for the GPIO serial RTC port: holds one accepted beat.
// Depends on gsrp_pkg.
module gsrp_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  gsrp_pkg::t_item i_item,
    input  logic           i_advance,   // core consumes the held beat
    output logic           o_valid,
    output gsrp_pkg::t_item o_item
);

    logic            r_valid;
    gsrp_pkg::t_item r_item;

    // Free when empty or when the held beat leaves this cycle
    assign o_ready = !r_valid || i_advance;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- src/gsrp_rtc_core.sv -----
// GPIO register file and bit-banged RTC command/response engine.
// Depends on gsrp_pkg and gpio_serial_rtc_port_macros.svh.
`include "gpio_serial_rtc_port_macros.svh"

module gsrp_rtc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,     // process the held beat this cycle
    input  gsrp_pkg::t_item   i_item,
    output gsrp_pkg::t_result o_result
);

    logic        r_reads_enable, n_reads_enable;
    logic [3:0]  r_pin_direction, n_pin_direction;
    logic [2:0]  r_pin_latch, n_pin_latch;
    logic [3:0]  r_bit_count, n_bit_count;
    logic [7:0]  r_command_byte, n_command_byte;
    logic [47:0] r_response_shift, n_response_shift;

    logic        is_write;
    logic        pin_wr;
    logic        rise;
    logic        sio_next;
    logic [7:0]  cmd_shift;
    logic [7:0]  cmd_final;
    logic [3:0]  bc_inc;

    assign is_write = (i_item.opcode == gsrp_pkg::OP_WRITE);
    assign pin_wr   = i_fire && is_write && (i_item.reg_index != gsrp_pkg::REG_DIR)
                      && (i_item.reg_index != gsrp_pkg::REG_RD_EN);
    assign rise     = !r_pin_latch[gsrp_pkg::PIN_CLK] && i_item.write_data[gsrp_pkg::PIN_CLK];
    assign cmd_shift = {r_command_byte[6:0], i_item.write_data[gsrp_pkg::PIN_SIO]};
    assign bc_inc    = r_bit_count + 4'd1;
    // Reverse unless the high nibble already marks a plain-order command
    assign cmd_final = ((cmd_shift & gsrp_pkg::CMD_HI_MASK) != gsrp_pkg::CMD_NO_REV)
                       ? gsrp_pkg::reverse8(cmd_shift) : cmd_shift;

    // Next-state logic
    always_comb begin
        n_reads_enable   = r_reads_enable;
        n_pin_direction  = r_pin_direction;
        n_pin_latch      = r_pin_latch;
        n_bit_count      = r_bit_count;
        n_command_byte   = r_command_byte;
        n_response_shift = r_response_shift;
        sio_next         = r_pin_latch[gsrp_pkg::PIN_SIO];

        if (i_fire && is_write && (i_item.reg_index == gsrp_pkg::REG_RD_EN)) begin
            n_reads_enable = i_item.write_data[0];
        end
        if (i_fire && is_write && (i_item.reg_index == gsrp_pkg::REG_DIR)) begin
            n_pin_direction = i_item.write_data;
        end

        if (pin_wr) begin
            if (!i_item.write_data[gsrp_pkg::PIN_SEL]) begin
                // Deselect: restart command and latch pins as written
                n_bit_count = '0;
                n_pin_latch = i_item.write_data[2:0];
            end else begin
                if (rise) begin
                    if (r_bit_count < gsrp_pkg::CMD_BITS) begin
                        n_bit_count    = bc_inc;
                        n_command_byte = cmd_shift;
                        if (bc_inc == gsrp_pkg::CMD_BITS) begin
                            n_command_byte = cmd_final;
                            if (cmd_final[0]) begin
                                case (cmd_final[3:1])
                                    gsrp_pkg::CMD_STATUS:   n_response_shift = gsrp_pkg::RSP_STATUS;
                                    gsrp_pkg::CMD_DATETIME: n_response_shift = gsrp_pkg::RSP_DATETIME;
                                    gsrp_pkg::CMD_TIME:     n_response_shift = gsrp_pkg::RSP_TIME;
                                    default:                n_response_shift = r_response_shift;
                                endcase
                            end
                        end
                    end else if (r_command_byte[0]) begin
                        // Read command: shift one response bit out, LSB first
                        sio_next         = r_response_shift[0];
                        n_response_shift = {1'b0, r_response_shift[47:1]};
                    end
                end
                n_pin_latch = {i_item.write_data[gsrp_pkg::PIN_SEL], sio_next,
                               i_item.write_data[gsrp_pkg::PIN_CLK]};
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reads_enable   <= 1'b0;
            r_pin_direction  <= '0;
            r_pin_latch      <= '0;
            r_bit_count      <= '0;
            r_command_byte   <= '0;
            r_response_shift <= '0;
        end else begin
            r_reads_enable   <= n_reads_enable;
            r_pin_direction  <= n_pin_direction;
            r_pin_latch      <= n_pin_latch;
            r_bit_count      <= n_bit_count;
            r_command_byte   <= n_command_byte;
            r_response_shift <= n_response_shift;
        end
    end

    // Read mux: result for read beats only
    always_comb begin
        o_result.valid = i_fire && !is_write;
        case (i_item.reg_index)
            gsrp_pkg::REG_RD_EN: o_result.read_data = {3'b000, r_reads_enable};
            gsrp_pkg::REG_DIR:   o_result.read_data = r_pin_direction;
            default:             o_result.read_data = {1'b0, r_pin_latch};
        endcase
    end

    // Checks
    `GSRP_ASSERT_NXT(a_desel_clears, i_clk, i_rst_n,
        pin_wr && !i_item.write_data[gsrp_pkg::PIN_SEL], r_bit_count == 4'd0,
        "bit counter not cleared on deselect")
    `GSRP_ASSERT_NXT(a_idle_rsp_hold, i_clk, i_rst_n,
        !pin_wr, $stable(r_response_shift) && $stable(r_bit_count),
        "RTC state moved without a pin data write")
    `GSRP_ASSERT_NXT(a_count_saturates, i_clk, i_rst_n,
        pin_wr && i_item.write_data[gsrp_pkg::PIN_SEL] && (r_bit_count == gsrp_pkg::CMD_BITS),
        r_bit_count == gsrp_pkg::CMD_BITS,
        "bit counter left its full value while selected")

endmodule

// ----- src/gsrp_out_stage.sv -----
// Result register for the GPIO serial RTC port master side.
// Depends on gsrp_pkg.
module gsrp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gsrp_pkg::t_result i_result,
    output logic              o_free,     // can take a result this cycle
    output logic              o_valid,
    input  logic              i_ready,
    output logic [3:0]        o_data
);

    logic       r_valid;
    logic [3:0] r_data;

    assign o_free = !r_valid || i_ready;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_result.valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (o_free && i_result.valid) begin
            r_data <= i_result.read_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- src/gpio_serial_rtc_port.sv -----
// Top level of the GPIO serial RTC port: input register, core, result register.
// Depends on gsrp_pkg, gsrp_in_stage, gsrp_rtc_core, gsrp_out_stage.
//
//  Channel   | Direction | Beat contents
//  s_axis    | in        | bus access: opcode, reg_index, write_data
//  m_axis    | out       | read_data, one beat per read access
//
// After slave acceptance the beat sits in the input register while the register file update
// and read mux load the result register; master valid rises once that register is loaded.
// One beat per cycle unless a read beat stalls; a write beat never waits on the master side.
// A read beat waits in the input register while the result register is full and stalled.
// Synchronous active-low reset clears all GPIO and RTC state and both valid flags.
module gpio_serial_rtc_port (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [0] opcode, [2:1] reg_index, [6:3] write_data, [7] zero
    input  logic [gsrp_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [3:0] read_data, [7:4] zero
    output logic [gsrp_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    gsrp_pkg::t_item   in_item;
    gsrp_pkg::t_item   held_item;
    gsrp_pkg::t_result result;
    logic              held_valid;
    logic              out_free;
    logic              advance;
    logic [3:0]        read_data;

    // Unpack the slave beat
    assign in_item.opcode     = i_s_axis_tdata[0];
    assign in_item.reg_index  = i_s_axis_tdata[2:1];
    assign in_item.write_data = i_s_axis_tdata[6:3];

    // Writes always proceed; reads need room in the result register
    assign advance = held_valid &&
                     ((held_item.opcode == gsrp_pkg::OP_WRITE) || out_free);

    gsrp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    gsrp_rtc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (held_item),
        .o_result (result)
    );

    gsrp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (result),
        .o_free   (out_free),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_data   (read_data)
    );

    assign o_m_axis_tdata = {{(gsrp_pkg::OUT_TDATA_W - 4){1'b0}}, read_data};

endmodule

// ----- tb/sv/gpio_serial_rtc_port_test.sv -----
// Self-checking bench for gpio_serial_rtc_port: bit-banged RTC sequences and register accesses.
// Predicts every read locally and checks the read_data beats in order.
// Depends on gsrp_pkg and the gpio_serial_rtc_port RTL only.
module gpio_serial_rtc_port_test;

    localparam logic [1:0] REG_PIN_LO  = 2'd0;
    localparam logic [1:0] REG_PIN_HI  = 2'd3;
    localparam int         HOLD_AT     = 200;
    localparam int         HOLD_LEN    = 48;
    localparam int         TAIL_BEATS  = 60;
    localparam int         STALL_LIMIT = 600;
    localparam int         DRAIN_WAIT  = 8;

    typedef struct packed {
        bit              drain;
        gsrp_pkg::t_item acc;
    } t_pend;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_data;

    t_pend           access_q[$];
    logic [3:0]      read_data_q[$];
    gsrp_pkg::t_item cur_acc = '0;
    int              n_beats = 0;
    int              in_beats = 0;
    int              out_beats = 0;
    int              errors = 0;

    // predicted GPIO / RTC state
    logic        rd_en_q = 1'b0;
    logic [3:0]  dir_q = '0;
    logic [2:0]  pins_q = '0;
    logic [3:0]  nbits_q = '0;
    logic [7:0]  cmd_q = '0;
    logic [47:0] reply_q = '0;

    gpio_serial_rtc_port DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [0] opcode, [2:1] reg_index, [6:3] write_data, [7] zero
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)    // [3:0] read_data, [7:4] zero
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [7:0] flip_byte(input logic [7:0] x);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = x[7 - i];
        end
        return r;
    endfunction

    // Pin data write: select, clock edge detect, command shift and reply shift
    task automatic predict_pin_write(input logic [2:0] v);
        if (!v[gsrp_pkg::PIN_SEL]) begin
            nbits_q = '0;
            pins_q  = v;
        end else begin
            if (!pins_q[gsrp_pkg::PIN_CLK] && v[gsrp_pkg::PIN_CLK]) begin
                if (nbits_q < gsrp_pkg::CMD_BITS) begin
                    cmd_q   = {cmd_q[6:0], v[gsrp_pkg::PIN_SIO]};
                    nbits_q = nbits_q + 4'd1;
                    if (nbits_q == gsrp_pkg::CMD_BITS) begin
                        if ((cmd_q & gsrp_pkg::CMD_HI_MASK) != gsrp_pkg::CMD_NO_REV)
                            cmd_q = flip_byte(cmd_q);
                        // only read commands with a known code load a reply
                        if (cmd_q[0]) begin
                            case (cmd_q[3:1])
                                gsrp_pkg::CMD_STATUS:   reply_q = gsrp_pkg::RSP_STATUS;
                                gsrp_pkg::CMD_DATETIME: reply_q = gsrp_pkg::RSP_DATETIME;
                                gsrp_pkg::CMD_TIME:     reply_q = gsrp_pkg::RSP_TIME;
                                default:                ;
                            endcase
                        end
                    end
                end else if (cmd_q[0]) begin
                    // exhausted reply shifts out zeros
                    pins_q[gsrp_pkg::PIN_SIO] = reply_q[0];
                    reply_q                   = reply_q >> 1;
                end
            end
            pins_q[gsrp_pkg::PIN_CLK] = v[gsrp_pkg::PIN_CLK];
            pins_q[gsrp_pkg::PIN_SEL] = v[gsrp_pkg::PIN_SEL];
        end
    endtask

    task automatic predict_access(input gsrp_pkg::t_item a, output bit has_rd,
                                  output logic [3:0] rd);
        has_rd = 1'b0;
        rd     = '0;
        if (a.opcode == gsrp_pkg::OP_WRITE) begin
            if (a.reg_index == gsrp_pkg::REG_RD_EN) rd_en_q = a.write_data[0];
            else if (a.reg_index == gsrp_pkg::REG_DIR) dir_q = a.write_data;
            else predict_pin_write(a.write_data[2:0]);
        end else begin
            has_rd = 1'b1;
            if (a.reg_index == gsrp_pkg::REG_RD_EN) rd = {3'b000, rd_en_q};
            else if (a.reg_index == gsrp_pkg::REG_DIR) rd = dir_q;
            else rd = {1'b0, pins_q};
        end
    endtask

    task automatic report_mismatch(input string what, input logic [3:0] got,
                                   input logic [3:0] want);
        errors++;
        $display("MISMATCH t=%0t beat %0d: %s got %h want %h",
                 $time, out_beats, what, got, want);
    endtask

    // Stimulus queue helpers
    task automatic push_access(input logic op, input logic [1:0] idx, input logic [3:0] wd);
        t_pend p;
        p.drain          = 1'b0;
        p.acc.opcode     = op;
        p.acc.reg_index  = idx;
        p.acc.write_data = wd;
        access_q.push_back(p);
        n_beats++;
    endtask

    task automatic push_drain();
        t_pend p;
        p       = '0;
        p.drain = 1'b1;
        access_q.push_back(p);
    endtask

    task automatic push_pins(input logic sel, input logic sio, input logic clk);
        logic [1:0] idx;
        idx = $urandom_range(0, 1) ? REG_PIN_HI : REG_PIN_LO;
        push_access(gsrp_pkg::OP_WRITE, idx, {1'($urandom_range(0, 1)), sel, sio, clk});
    endtask

    task automatic queue_noise();
        push_access(1'($urandom), 2'($urandom), 4'($urandom));
    endtask

    // One framed RTC transfer: select low, command MSB first, then reply clocks
    task automatic queue_rtc_xfer(input logic [7:0] sent, input int nread);
        logic [1:0] idx;
        push_pins(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        push_pins(1'b1, 1'($urandom_range(0, 1)), 1'b0);
        for (int i = 7; i >= 0; i--) begin
            if ($urandom_range(0, 15) == 0) queue_noise();
            push_pins(1'b1, 1'($urandom_range(0, 1)), 1'b0);
            push_pins(1'b1, sent[i], 1'b1);
        end
        for (int k = 0; k < nread; k++) begin
            if ($urandom_range(0, 19) == 0) queue_noise();
            push_pins(1'b1, 1'($urandom_range(0, 1)), 1'b0);
            push_pins(1'b1, 1'($urandom_range(0, 1)), 1'b1);
            if ($urandom_range(0, 2) != 0) begin
                idx = $urandom_range(0, 1) ? REG_PIN_HI : REG_PIN_LO;
                push_access(gsrp_pkg::OP_READ, idx, 4'($urandom));
            end
        end
    endtask

    // Driver: beats from access_q, prediction at acceptance
    int tx_gap = 0;
    int tx_gap_pct = 20;
    int tx_cyc = 0;
    int rx_hold = 0;

    always @(posedge i_clk) begin
        bit         has_rd;
        logic [3:0] rd;
        logic       nxt_valid;
        t_pend      p;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            nxt_valid = s_valid;
            tx_cyc++;
            if (tx_cyc % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0:       tx_gap_pct = 0;
                    1:       tx_gap_pct = 10;
                    default: tx_gap_pct = 35;
                endcase
            end
            if (s_valid && s_ready) begin
                predict_access(cur_acc, has_rd, rd);
                if (has_rd) read_data_q.push_back(rd);
                in_beats++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                // pause point: hold until every predicted read has come back
                if (access_q.size() != 0 && access_q[0].drain && read_data_q.size() == 0)
                    void'(access_q.pop_front());
                if (tx_gap != 0) begin
                    tx_gap--;
                end else if (access_q.size() != 0 && !access_q[0].drain) begin
                    if (in_beats + TAIL_BEATS < n_beats && rx_hold == 0 &&
                        $urandom_range(0, 99) < tx_gap_pct) begin
                        tx_gap = $urandom_range(0, 8);
                    end else begin
                        p         = access_q.pop_front();
                        cur_acc   = p.acc;
                        nxt_valid = 1'b1;
                    end
                end
            end
            s_valid <= nxt_valid;
            s_data  <= {1'b0, cur_acc.write_data, cur_acc.reg_index, cur_acc.opcode};
        end
    end

    // Monitor: checks read_data beats, drives tready with stall bursts
    int  rx_gap = 0;
    int  rx_gap_pct = 20;
    int  rx_cyc = 0;
    bit  hold_done = 1'b0;

    always @(posedge i_clk) begin
        logic [3:0] want;
        logic       nxt_ready;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            rx_cyc++;
            if (rx_cyc % 64 == 32) begin
                case ($urandom_range(0, 2))
                    0:       rx_gap_pct = 0;
                    1:       rx_gap_pct = 8;
                    default: rx_gap_pct = 30;
                endcase
            end
            if (m_valid && m_ready) begin
                if (read_data_q.size() == 0) begin
                    report_mismatch("unexpected read_data", m_data[3:0], 4'h0);
                end else begin
                    want = read_data_q.pop_front();
                    if (m_data[3:0] !== want) report_mismatch("read_data", m_data[3:0], want);
                end
                out_beats++;
            end
            nxt_ready = 1'b0;
            if (rx_hold != 0) begin
                rx_hold--;
            end else if (!hold_done && in_beats >= HOLD_AT) begin
                // long back-pressure so the pipeline fills and stalls the input
                hold_done = 1'b1;
                rx_hold   = HOLD_LEN - 1;
            end else if (rx_gap != 0) begin
                rx_gap--;
            end else if (in_beats + TAIL_BEATS < n_beats &&
                         $urandom_range(0, 99) < rx_gap_pct) begin
                rx_gap = $urandom_range(0, 8);
            end else begin
                nxt_ready = 1'b1;
            end
            m_ready <= nxt_ready;
        end
    end

    // Watchdog on cycles with no beat on either side
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus and end of run
    initial begin
        logic [7:0] fin;
        logic [7:0] sent;
        int         nread;
        bit         mid_drain;
        mid_drain = 1'b0;

        // directed: reset values, register extremes, select and edge cases
        for (int r = 0; r < 4; r++) push_access(gsrp_pkg::OP_READ, 2'(r), 4'hF);
        push_access(gsrp_pkg::OP_WRITE, gsrp_pkg::REG_DIR, 4'hF);
        push_access(gsrp_pkg::OP_READ, gsrp_pkg::REG_DIR, 4'h0);
        push_access(gsrp_pkg::OP_WRITE, gsrp_pkg::REG_DIR, 4'h0);
        push_access(gsrp_pkg::OP_READ, gsrp_pkg::REG_DIR, 4'hF);
        push_access(gsrp_pkg::OP_WRITE, gsrp_pkg::REG_DIR, 4'hA);
        push_access(gsrp_pkg::OP_WRITE, gsrp_pkg::REG_RD_EN, 4'hE);
        push_access(gsrp_pkg::OP_READ, gsrp_pkg::REG_RD_EN, 4'h0);
        push_access(gsrp_pkg::OP_WRITE, gsrp_pkg::REG_RD_EN, 4'h1);
        push_access(gsrp_pkg::OP_READ, gsrp_pkg::REG_RD_EN, 4'h0);
        push_access(gsrp_pkg::OP_WRITE, REG_PIN_LO, 4'b1011);  // select low latches pins
        push_access(gsrp_pkg::OP_READ, REG_PIN_HI, 4'h0);
        push_access(gsrp_pkg::OP_WRITE, REG_PIN_HI, 4'b1100);  // select high, serial bit held
        push_access(gsrp_pkg::OP_WRITE, REG_PIN_LO, 4'b0111);  // rising clock shifts a bit
        push_access(gsrp_pkg::OP_READ, REG_PIN_LO, 4'h0);
        push_access(gsrp_pkg::OP_WRITE, REG_PIN_LO, 4'b0111);  // no edge
        push_access(gsrp_pkg::OP_READ, REG_PIN_HI, 4'h0);
        push_access(gsrp_pkg::OP_WRITE, REG_PIN_HI, 4'h0);
        push_access(gsrp_pkg::OP_READ, REG_PIN_LO, 4'h0);
        push_access(gsrp_pkg::OP_READ, gsrp_pkg::REG_RD_EN, 4'h0);
        push_drain();

        // random: mostly framed transfers, some noise and broken frames
        while (n_beats < 420) begin
            if ($urandom_range(0, 9) < 7) begin
                fin[0]   = ($urandom_range(0, 3) != 0);
                fin[3:1] = 3'($urandom_range(0, 7));
                fin[7:4] = 4'($urandom_range(0, 15));
                sent     = $urandom_range(0, 1) ? {gsrp_pkg::CMD_NO_REV[7:4], fin[3:0]}
                                                : flip_byte(fin);
                nread    = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 52)
                                                       : $urandom_range(0, 10);
                queue_rtc_xfer(sent, nread);
            end else begin
                repeat ($urandom_range(1, 4)) queue_noise();
            end
            if (!mid_drain && n_beats > 260) begin
                mid_drain = 1'b1;
                push_drain();
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (in_beats != n_beats) @(posedge i_clk);
        while (read_data_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
